@@ sv/chc_pkg.sv @@
// Shared constants, types and lookup functions for the cartridge header checker.
package chc_pkg;

	localparam int AddrW = 15;
	localparam int DataW = 8;

	localparam logic [AddrW-1:0] LogoStart  = 15'h104;
	localparam logic [AddrW-1:0] LogoEnd    = 15'h133;
	localparam logic [AddrW-1:0] SumStart   = 15'h134;
	localparam logic [AddrW-1:0] SumEnd     = 15'h14C;
	localparam logic [AddrW-1:0] Trailer    = 15'h14D;
	localparam logic [AddrW-1:0] TypeAddr   = 15'h147;
	localparam logic [AddrW-1:0] RomSzAddr  = 15'h148;
	localparam logic [AddrW-1:0] RamSzAddr  = 15'h149;
	localparam logic [AddrW-1:0] RegionAddr = 15'h14A;

	localparam logic [2:0] MapPlain   = 3'd0;
	localparam logic [2:0] MapMbc1    = 3'd1;
	localparam logic [2:0] MapMbc2    = 3'd2;
	localparam logic [2:0] MapMmm01   = 3'd3;
	localparam logic [2:0] MapMbc3    = 3'd4;
	localparam logic [2:0] MapMbc4    = 3'd5;
	localparam logic [2:0] MapMbc5    = 3'd6;
	localparam logic [2:0] MapUnknown = 3'd7;

	localparam logic [3:0] RomIdxOther = 4'd11;
	localparam logic [7:0] RomBigBias  = 8'd74;
	localparam logic [2:0] RamIdxMax   = 3'd4;
	localparam logic [1:0] RegionMax   = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [AddrW-1:0] address;
		logic [DataW-1:0] data;
	} beat_t;

	typedef struct packed {
		logic       header_ok;
		logic       logo_ok;
		logic       checksum_ok;
		logic [7:0] computed_checksum;
		logic [2:0] mapper_kind;
		logic [3:0] rom_size_index;
		logic [2:0] ram_size_index;
		logic [1:0] region_index;
		logic [7:0] version;
	} result_t;

	function automatic logic [7:0] logo_byte(input logic [5:0] idx);
		logic [7:0] b;
		case (idx)
			6'd0:  b = 8'hCE; 6'd1:  b = 8'hED; 6'd2:  b = 8'h66; 6'd3:  b = 8'h66;
			6'd4:  b = 8'hCC; 6'd5:  b = 8'h0D; 6'd6:  b = 8'h00; 6'd7:  b = 8'h0B;
			6'd8:  b = 8'h03; 6'd9:  b = 8'h73; 6'd10: b = 8'h00; 6'd11: b = 8'h83;
			6'd12: b = 8'h00; 6'd13: b = 8'h0C; 6'd14: b = 8'h00; 6'd15: b = 8'h0D;
			6'd16: b = 8'h00; 6'd17: b = 8'h08; 6'd18: b = 8'h11; 6'd19: b = 8'h1F;
			6'd20: b = 8'h88; 6'd21: b = 8'h89; 6'd22: b = 8'h00; 6'd23: b = 8'h0E;
			6'd24: b = 8'hDC; 6'd25: b = 8'hCC; 6'd26: b = 8'h6E; 6'd27: b = 8'hE6;
			6'd28: b = 8'hDD; 6'd29: b = 8'hDD; 6'd30: b = 8'hD9; 6'd31: b = 8'h99;
			6'd32: b = 8'hBB; 6'd33: b = 8'hBB; 6'd34: b = 8'h67; 6'd35: b = 8'h63;
			6'd36: b = 8'h6E; 6'd37: b = 8'h0E; 6'd38: b = 8'hEC; 6'd39: b = 8'hCC;
			6'd40: b = 8'hDD; 6'd41: b = 8'hDC; 6'd42: b = 8'h99; 6'd43: b = 8'h9F;
			6'd44: b = 8'hBB; 6'd45: b = 8'hB9; 6'd46: b = 8'h33; 6'd47: b = 8'h3E;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [2:0] mapper_of(input logic [7:0] t);
		logic [2:0] m;
		case (t) inside
			8'h00, 8'h08, 8'h09:  m = MapPlain;
			[8'h01:8'h03]:        m = MapMbc1;
			8'h05, 8'h06:         m = MapMbc2;
			[8'h0B:8'h0D]:        m = MapMmm01;
			[8'h0F:8'h13]:        m = MapMbc3;
			[8'h15:8'h17]:        m = MapMbc4;
			[8'h19:8'h1E]:        m = MapMbc5;
			default:              m = MapUnknown;
		endcase
		return m;
	endfunction

	function automatic logic [3:0] rom_index_of(input logic [7:0] d);
		logic [7:0] t;
		logic [3:0] r;
		t = d - RomBigBias;
		if (d >= 8'h52 && d <= 8'h54)
			r = t[3:0];
		else if (d > 8'd7)
			r = RomIdxOther;
		else
			r = d[3:0];
		return r;
	endfunction

endpackage

@@ sv/cartridge_header_checker.sv @@
// Top level of the cartridge header checker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------
//  in      | sink      | in_valid / in_stall  | address, data
//  out     | source    | out_valid / out_stall| header_ok .. version (nine fields)
//
// One byte per cycle while in_stall is low; an accepted trailer beat passes through the
// input register, then the result register.
// Only trailer beats need the result register: other bytes keep flowing while a
// summary is stalled at the output, and a trailer waits in the input register.
// Asynchronous reset returns the header state to its restart values, logo match flag set; no clearing pass.
module cartridge_header_checker
	import chc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [AddrW-1:0] address,
	input  logic [DataW-1:0] data,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             header_ok,
	output logic             logo_ok,
	output logic             checksum_ok,
	output logic [7:0]       computed_checksum,
	output logic [2:0]       mapper_kind,
	output logic [3:0]       rom_size_index,
	output logic [2:0]       ram_size_index,
	output logic [1:0]       region_index,
	output logic [7:0]       version
);

	beat_t   beat_s1;
	result_t result, result_q;
	logic    advance, fire, is_trailer, out_free;

	assign advance = !beat_s1.valid || !is_trailer || out_free;
	assign fire    = beat_s1.valid && advance;

	chc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.address  (address),
		.data     (data),
		.advance  (advance),
		.in_stall (in_stall),
		.beat_s1  (beat_s1)
	);

	chc_hdr_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_s1    (beat_s1),
		.fire       (fire),
		.is_trailer (is_trailer),
		.result     (result)
	);

	chc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && is_trailer),
		.result    (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign header_ok         = result_q.header_ok;
	assign logo_ok           = result_q.logo_ok;
	assign checksum_ok       = result_q.checksum_ok;
	assign computed_checksum = result_q.computed_checksum;
	assign mapper_kind       = result_q.mapper_kind;
	assign rom_size_index    = result_q.rom_size_index;
	assign ram_size_index    = result_q.ram_size_index;
	assign region_index      = result_q.region_index;
	assign version           = result_q.version;

endmodule

@@ sv/chc_in_stage.sv @@
// Input register: holds one beat until the header stage takes it.
module chc_in_stage
	import chc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [AddrW-1:0] address,
	input  logic [DataW-1:0] data,
	input  logic             advance,
	output logic             in_stall,
	output beat_t            beat_s1
);

	logic             valid_s1;
	logic [AddrW-1:0] address_s1;
	logic [DataW-1:0] data_s1;

	assign in_stall = !advance;
	assign beat_s1  = {valid_s1, address_s1, data_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			address_s1 <= address;
			data_s1    <= data;
		end
	end

endmodule

@@ sv/chc_hdr_core.sv @@
// Header state: logo match, running checksum, captured fields and the trailer summary.
module chc_hdr_core
	import chc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  beat_t   beat_s1,
	input  logic    fire,
	output logic    is_trailer,
	output result_t result
);

	logic       logo_match_q;
	logic [7:0] checksum_q;
	logic [2:0] mapper_q;
	logic [3:0] rom_idx_q;
	logic [2:0] ram_idx_q;
	logic [1:0] region_q;
	logic [7:0] version_q;

	logic       restart, in_logo, in_sum, byte_match, sum_ok;
	logic [5:0] logo_idx;
	logic [AddrW-1:0] logo_off;
	logic [7:0] sum_base;

	assign restart  = beat_s1.address == LogoStart;
	assign in_logo  = beat_s1.address >= LogoStart && beat_s1.address <= LogoEnd;
	assign in_sum   = beat_s1.address >= SumStart && beat_s1.address <= SumEnd;
	assign is_trailer = beat_s1.address == Trailer;
	assign logo_off = beat_s1.address - LogoStart;
	assign logo_idx = logo_off[5:0];
	assign byte_match = beat_s1.data == logo_byte(logo_idx);
	assign sum_base = checksum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logo_match_q <= 1'b1;
			checksum_q   <= '0;
			mapper_q     <= MapPlain;
			rom_idx_q    <= '0;
			ram_idx_q    <= '0;
			region_q     <= '0;
			version_q    <= '0;
		end else if (fire) begin
			if (restart) begin
				// first logo byte also restarts the whole header
				logo_match_q <= byte_match;
				checksum_q   <= '0;
				mapper_q     <= MapPlain;
				rom_idx_q    <= '0;
				ram_idx_q    <= '0;
				region_q     <= '0;
				version_q    <= '0;
			end else if (in_logo) begin
				if (!byte_match)
					logo_match_q <= 1'b0;
			end else if (in_sum) begin
				checksum_q <= sum_base - beat_s1.data - 8'd1;
				case (beat_s1.address)
					TypeAddr:   mapper_q  <= mapper_of(beat_s1.data);
					RomSzAddr:  rom_idx_q <= rom_index_of(beat_s1.data);
					RamSzAddr:  ram_idx_q <= (beat_s1.data > 8'd3) ? RamIdxMax
					                         : beat_s1.data[2:0];
					RegionAddr: region_q  <= (beat_s1.data > 8'd2) ? RegionMax
					                         : beat_s1.data[1:0];
					SumEnd:     version_q <= beat_s1.data;
					default: ;
				endcase
			end
		end
	end

	assign sum_ok = beat_s1.data == checksum_q;

	always_comb begin
		result.header_ok         = sum_ok && logo_match_q;
		result.logo_ok           = logo_match_q;
		result.checksum_ok       = sum_ok;
		result.computed_checksum = checksum_q;
		result.mapper_kind       = mapper_q;
		result.rom_size_index    = rom_idx_q;
		result.ram_size_index    = ram_idx_q;
		result.region_index      = region_q;
		result.version           = version_q;
	end

endmodule

@@ sv/chc_out_reg.sv @@
// Result register: holds the trailer summary until the sink takes the beat.
module chc_out_reg
	import chc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result,
	input  logic    out_stall,
	output logic    out_free,
	output logic    out_valid,
	output result_t result_q
);

	assign out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			result_q <= result;
	end

endmodule

@@ sv/chc_checker.sv @@
// Port-level checks for the cartridge header checker, bound to the top level.
module chc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       header_ok,
	input logic       logo_ok,
	input logic       checksum_ok,
	input logic [7:0] computed_checksum,
	input logic [2:0] mapper_kind,
	input logic [3:0] rom_size_index,
	input logic [2:0] ram_size_index,
	input logic [1:0] region_index,
	input logic [7:0] version
);

	// a stalled summary beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(computed_checksum)
		&& $stable(version) && $stable(mapper_kind) && $stable(logo_ok))
		else $error("stalled result beat changed");

	a_ok_and: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> header_ok == (logo_ok && checksum_ok))
		else $error("header_ok disagrees with logo and checksum flags");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rom_size_index <= 4'd11 && ram_size_index <= 3'd4
		&& region_index <= 2'd2)
		else $error("clamped index out of range");

	// with nothing in flight the input is never held off
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_valid |=> !in_stall || in_valid || $past(in_valid))
		else $error("input stalled with an empty pipeline");

endmodule

bind cartridge_header_checker chc_checker u_chc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_valid),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.header_ok         (header_ok),
	.logo_ok           (logo_ok),
	.checksum_ok       (checksum_ok),
	.computed_checksum (computed_checksum),
	.mapper_kind       (mapper_kind),
	.rom_size_index    (rom_size_index),
	.ram_size_index    (ram_size_index),
	.region_index      (region_index),
	.version           (version)
);
